>>> src/mcct_pkg.sv
// ----------------------------------------------------------------------------
// mcct_pkg: shared types and constants for the moving circle collision test
// Holds the stream layout, fixed-point widths, CORDIC constants and the
// arctangent step table.
// ----------------------------------------------------------------------------
package mcct_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_STEPS      = 24;

    localparam int POS_W   = 17;
    localparam int SPEED_W = 14;
    localparam int HEAD_W  = 16;
    localparam int RAD_W   = 12;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 8;

    // CORDIC datapath: Q30 x/y with headroom, angle at 2^24 per turn
    localparam int CX_W = 33;
    localparam int CZ_W = 26;

    localparam logic signed [CX_W-1:0] CORDIC_START = 33'sd652032874;
    localparam logic [RAD_W-1:0]       RADIUS_RESET = 12'd832;

    // Width of the unsigned operands of the wide multipliers
    localparam int MAG_W = 40;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cord;

    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic [SPEED_W-1:0]      speed1;
        logic [SPEED_W-1:0]      speed2;
        logic                    flip1;
        logic                    flip2;
    } t_side;

    typedef struct packed {
        logic zero_motion;
        logic excess_pos;
        logic proj_pos;
        logic cr_gt;
        logic lead_pos;
    } t_flags;

    // Arctangent of 2^-idx, 2^24 counts per turn
    function automatic logic signed [CZ_W-1:0] atan_step(input int idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            0:  v = 26'sd2097152;
            1:  v = 26'sd1238021;
            2:  v = 26'sd654136;
            3:  v = 26'sd332050;
            4:  v = 26'sd166669;
            5:  v = 26'sd83416;
            6:  v = 26'sd41718;
            7:  v = 26'sd20860;
            8:  v = 26'sd10430;
            9:  v = 26'sd5215;
            10: v = 26'sd2608;
            11: v = 26'sd1304;
            12: v = 26'sd652;
            13: v = 26'sd326;
            14: v = 26'sd163;
            15: v = 26'sd81;
            16: v = 26'sd41;
            17: v = 26'sd20;
            18: v = 26'sd10;
            19: v = 26'sd5;
            20: v = 26'sd3;
            21: v = 26'sd1;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/moving_circle_collision_test_unit.sv
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the CORDIC
// cell chain and the wide multipliers are fully pipelined, so a new pair
// enters every cycle. A stalled output freezes the whole pipeline; input
// ready follows it. Reset (synchronous, active low) empties the pipeline and
// sets the radius to 832.
// ----------------------------------------------------------------------------
// moving_circle_collision_test_unit: contact test of two moving circles
// Builds both velocities with two chains of CORDIC cells, then tests the pair
// with exact integer comparisons on squared quantities.
// ----------------------------------------------------------------------------
module moving_circle_collision_test_unit #(
    parameter int CORDIC_ITERATIONS = mcct_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config: ball_radius
    input  logic                                i_cfg_wr_en,
    input  logic [mcct_pkg::RAD_W-1:0]          i_cfg_wr_data,
    // input items
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata, low bit up: first_x[16:0], first_y[33:17], first_speed[47:34],
    // first_heading[63:48], second_x[80:64], second_y[97:81],
    // second_speed[111:98], second_heading[127:112]
    input  logic [mcct_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result items
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata, low bit up: hit[0], zero fill [7:1]
    output logic [mcct_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int N   = CORDIC_ITERATIONS;
    localparam int LAT = N + 8;
    localparam int MW  = mcct_pkg::MAG_W;

    // ---------------------------------------------------------------
    // Flow control: every stage advances together
    // ---------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;
    logic           r_out_valid;
    logic           r_out_hit;
    logic [mcct_pkg::RAD_W-1:0] r_radius;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_radius    <= mcct_pkg::RADIUS_RESET;
        end else begin
            if (en) begin
                r_vld       <= {r_vld[LAT-2:0], i_s_tvalid};
                r_out_valid <= r_vld[LAT-1];
            end
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Unpack and fold headings to [-90, 90) degrees
    // ---------------------------------------------------------------
    logic [mcct_pkg::HEAD_W-1:0] h1, h2, h1f, h2f, h1s, h2s;
    logic                        flip1, flip2;
    mcct_pkg::t_side             in_side;
    mcct_pkg::t_cord             chain1 [N+1];
    mcct_pkg::t_cord             chain2 [N+1];

    always_comb begin
        h1    = i_s_tdata[63:48];
        h2    = i_s_tdata[127:112];
        h1s   = h1 + 16'h4000;
        h2s   = h2 + 16'h4000;
        flip1 = h1s[15];
        flip2 = h2s[15];
        h1f   = flip1 ? (h1 ^ 16'h8000) : h1;
        h2f   = flip2 ? (h2 ^ 16'h8000) : h2;

        chain1[0].x = mcct_pkg::CORDIC_START;
        chain1[0].y = '0;
        chain1[0].z = mcct_pkg::CZ_W'($signed({h1f, 8'h00}));
        chain2[0].x = mcct_pkg::CORDIC_START;
        chain2[0].y = '0;
        chain2[0].z = mcct_pkg::CZ_W'($signed({h2f, 8'h00}));

        in_side.x1     = i_s_tdata[16:0];
        in_side.y1     = i_s_tdata[33:17];
        in_side.speed1 = i_s_tdata[47:34];
        in_side.x2     = i_s_tdata[80:64];
        in_side.y2     = i_s_tdata[97:81];
        in_side.speed2 = i_s_tdata[111:98];
        in_side.flip1  = flip1;
        in_side.flip2  = flip2;
    end

    // ---------------------------------------------------------------
    // CORDIC cell chains, one per circle, with a matching side line
    // ---------------------------------------------------------------
    for (genvar k = 0; k < N; k++) begin : g_cell
        mcct_cordic_cell #(.STEP(k)) u_cell1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (chain1[k]),
            .o_q   (chain1[k+1])
        );
        mcct_cordic_cell #(.STEP(k)) u_cell2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (chain2[k]),
            .o_q   (chain2[k+1])
        );
    end

    mcct_pkg::t_side r_side [N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= in_side;
            for (int k = 1; k < N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // P1: scale by speed and round; form the centre gap
    // ---------------------------------------------------------------
    mcct_pkg::t_side         sd;
    logic signed [32:0]      c1x, c1y, c2x, c2y;
    logic signed [47:0]      p1x, p1y, p2x, p2y;
    logic signed [17:0]      dgx, dgy;
    logic signed [16:0]      r_ax, r_ay, r_bx, r_by;
    logic signed [19:0]      r_gx1, r_gy1;
    logic [14:0]             r_reach1;

    always_comb begin
        sd  = r_side[N-1];
        c1x = sd.flip1 ? -chain1[N].x : chain1[N].x;
        c1y = sd.flip1 ? -chain1[N].y : chain1[N].y;
        c2x = sd.flip2 ? -chain2[N].x : chain2[N].x;
        c2y = sd.flip2 ? -chain2[N].y : chain2[N].y;
        // round to nearest with a floor shift
        p1x = $signed({1'b0, sd.speed1}) * c1x + (48'sd1 <<< 29);
        p1y = $signed({1'b0, sd.speed1}) * c1y + (48'sd1 <<< 29);
        p2x = $signed({1'b0, sd.speed2}) * c2x + (48'sd1 <<< 29);
        p2y = $signed({1'b0, sd.speed2}) * c2y + (48'sd1 <<< 29);
        dgx = 18'(sd.x2) - 18'(sd.x1);
        dgy = 18'(sd.y2) - 18'(sd.y1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax     <= p1x[46:30];
            r_ay     <= p1y[46:30];
            r_bx     <= p2x[46:30];
            r_by     <= p2y[46:30];
            r_gx1    <= {dgx, 2'b00};
            r_gy1    <= {dgy, 2'b00};
            r_reach1 <= {r_radius, 3'b000};
        end
    end

    // ---------------------------------------------------------------
    // P2: relative velocity
    // ---------------------------------------------------------------
    logic signed [17:0] r_rx, r_ry;
    logic signed [19:0] r_gx2, r_gy2;
    logic [14:0]        r_reach2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx     <= 18'(r_ax) - 18'(r_bx);
            r_ry     <= 18'(r_ay) - 18'(r_by);
            r_gx2    <= r_gx1;
            r_gy2    <= r_gy1;
            r_reach2 <= r_reach1;
        end
    end

    // ---------------------------------------------------------------
    // P3: squares and dot-product terms
    // ---------------------------------------------------------------
    logic signed [35:0] r_rxx, r_ryy;
    logic signed [39:0] r_gxx, r_gyy;
    logic signed [37:0] r_rgx, r_rgy;
    logic [29:0]        r_rsq3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rxx  <= r_rx * r_rx;
            r_ryy  <= r_ry * r_ry;
            r_gxx  <= r_gx2 * r_gx2;
            r_gyy  <= r_gy2 * r_gy2;
            r_rgx  <= 38'(r_rx) * 38'(r_gx2);
            r_rgy  <= 38'(r_ry) * 38'(r_gy2);
            r_rsq3 <= r_reach2 * r_reach2;
        end
    end

    // ---------------------------------------------------------------
    // P4: projection, and centre distance and motion length squared
    // ---------------------------------------------------------------
    logic signed [47:0] r_cs, r_ms, r_pj, r_rs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs <= 48'(r_gxx) + 48'(r_gyy);
            r_ms <= 48'(r_rxx) + 48'(r_ryy);
            r_pj <= 48'(r_rgx) + 48'(r_rgy);
            r_rs <= $signed({18'd0, r_rsq3});
        end
    end

    // ---------------------------------------------------------------
    // P5: differences, signs and magnitudes for the wide products
    // ---------------------------------------------------------------
    logic signed [47:0] exs, crs, lds, pja, crm;
    logic [MW-1:0]      r_ex_mag, r_pr_mag, r_cr_mag, r_ld_mag, r_ms_mag, r_r4;
    mcct_pkg::t_flags   n_f5, r_f5, r_f6, r_f7;

    always_comb begin
        exs = r_cs - r_ms - r_rs;
        crs = r_cs - r_rs;
        lds = r_pj - r_ms;
        pja = r_pj[47] ? -r_pj : r_pj;
        crm = crs[47] ? -crs : crs;
        n_f5.zero_motion = (r_ms == '0);
        n_f5.excess_pos  = !exs[47] && (exs != '0);
        n_f5.proj_pos    = !r_pj[47] && (r_pj != '0);
        n_f5.cr_gt       = !crs[47] && (crs != '0);
        n_f5.lead_pos    = !lds[47] && (lds != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex_mag <= exs[MW-1:0];
            r_pr_mag <= pja[MW-1:0];
            r_cr_mag <= crm[MW-1:0];
            r_ld_mag <= lds[MW-1:0];
            r_ms_mag <= r_ms[MW-1:0];
            r_r4     <= MW'({r_rs[29:0], 2'b00});
            r_f5     <= n_f5;
            r_f6     <= r_f5;
            r_f7     <= r_f6;
        end
    end

    // ---------------------------------------------------------------
    // P6-P7: wide products, two stages each
    // ---------------------------------------------------------------
    logic [2*MW-1:0] e2, r4m, p2, cm, l2;

    mcct_mul #(.W(MW)) u_mul_e2 (
        .i_clk (i_clk), .i_en (en), .i_a (r_ex_mag), .i_b (r_ex_mag), .o_p (e2)
    );
    mcct_mul #(.W(MW)) u_mul_r4m (
        .i_clk (i_clk), .i_en (en), .i_a (r_r4), .i_b (r_ms_mag), .o_p (r4m)
    );
    mcct_mul #(.W(MW)) u_mul_p2 (
        .i_clk (i_clk), .i_en (en), .i_a (r_pr_mag), .i_b (r_pr_mag), .o_p (p2)
    );
    mcct_mul #(.W(MW)) u_mul_cm (
        .i_clk (i_clk), .i_en (en), .i_a (r_cr_mag), .i_b (r_ms_mag), .o_p (cm)
    );
    mcct_mul #(.W(MW)) u_mul_l2 (
        .i_clk (i_clk), .i_en (en), .i_a (r_ld_mag), .i_b (r_ld_mag), .o_p (l2)
    );

    // ---------------------------------------------------------------
    // P8: early rejects and the remaining term for the contact test
    // ---------------------------------------------------------------
    logic            hit_a, rej_ca;
    logic [2*MW:0]   n_rest;
    logic            r_hit8, r_lead8;
    logic [2*MW-1:0] r_l2;
    logic [2*MW:0]   r_rest;

    always_comb begin
        // drop on zero motion, rim gap beyond motion, or receding pair
        hit_a = !r_f7.zero_motion
             && !(r_f7.excess_pos && (e2 > r4m))
             && r_f7.proj_pos;
        if (r_f7.cr_gt) begin
            rej_ca = cm > p2;
            n_rest = {1'b0, p2} - {1'b0, cm};
        end else begin
            rej_ca = 1'b0;
            n_rest = {1'b0, p2} + {1'b0, cm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit8  <= hit_a && !rej_ca;
            r_lead8 <= r_f7.lead_pos;
            r_l2    <= l2;
            r_rest  <= n_rest;
        end
    end

    // ---------------------------------------------------------------
    // Output register: first contact must lie within the motion
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= r_hit8 && !(r_lead8 && ({1'b0, r_l2} > r_rest));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(mcct_pkg::OUT_TDATA_W-1){1'b0}}, r_out_hit};

`ifndef SYNTHESIS
    // Reset empties the whole pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !o_m_tvalid)
        else $error("pipeline not empty after reset");

    // A stalled output freezes every stage
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_vld) && $stable(r_hit8))
        else $error("pipeline moved during output stall");

    // A pair rejected early never reports a hit
    a_early_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[LAT-1] && !r_hit8) |=> o_m_tvalid && !o_m_tdata[0])
        else $error("hit reported after early reject");

    // Zero relative motion is rejected at the decision stage
    a_zero_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[N+6] && r_f7.zero_motion) |=> !r_hit8)
        else $error("zero motion passed the reject stage");
`endif

endmodule

>>> src/mcct_cordic_cell.sv
// ----------------------------------------------------------------------------
// mcct_cordic_cell: one CORDIC rotation step
// Rotates toward zero residual angle and registers the result for the
// next cell in the chain.
// ----------------------------------------------------------------------------
module mcct_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  mcct_pkg::t_cord     i_d,
    output mcct_pkg::t_cord     o_q
);

    mcct_pkg::t_cord r_q;
    mcct_pkg::t_cord n_q;

    always_comb begin
        if (!i_d.z[mcct_pkg::CZ_W-1]) begin
            n_q.x = i_d.x - (i_d.y >>> STEP);
            n_q.y = i_d.y + (i_d.x >>> STEP);
            n_q.z = i_d.z - mcct_pkg::atan_step(STEP);
        end else begin
            n_q.x = i_d.x + (i_d.y >>> STEP);
            n_q.y = i_d.y - (i_d.x >>> STEP);
            n_q.z = i_d.z + mcct_pkg::atan_step(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> src/mcct_mul.sv
// ----------------------------------------------------------------------------
// mcct_mul: two-stage unsigned multiplier
// Splits each operand in halves, registers four partial products, then
// registers their sum.
// ----------------------------------------------------------------------------
module mcct_mul #(
    parameter int W = mcct_pkg::MAG_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [2*W-1:0]   o_p
);

    localparam int H = W / 2;
    localparam int L = W - H;

    logic [2*H-1:0] r_p00;
    logic [H+L-1:0] r_p01;
    logic [L+H-1:0] r_p10;
    logic [2*L-1:0] r_p11;
    logic [2*W-1:0] r_p;
    logic [2*W-1:0] n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= i_a[H-1:0] * i_b[H-1:0];
            r_p01 <= i_a[H-1:0] * i_b[W-1:H];
            r_p10 <= i_a[W-1:H] * i_b[H-1:0];
            r_p11 <= i_a[W-1:H] * i_b[W-1:H];
            r_p   <= n_p;
        end
    end

    always_comb begin
        n_p = (2*W)'(r_p00)
            + ((2*W)'(r_p01) << H)
            + ((2*W)'(r_p10) << H)
            + ((2*W)'(r_p11) << (2*H));
    end

    assign o_p = r_p;

endmodule
